// ----- sv/hsv_to_rgb_convert_defines.svh -----
// Assertion macros shared by the converter RTL.
`ifndef HSV_TO_RGB_CONVERT_DEFINES_SVH
`define HSV_TO_RGB_CONVERT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define HSV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define HSV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSV_ASSERT(label, clk, rst, prop, msg)
`define HSV_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- sv/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

   // Field widths fixed by the pixel format
   localparam int unsigned HUE_W  = 13;
   localparam int unsigned FRAC_W = 10;
   localparam int unsigned SECT_W = 3;

   // Hue range and sector span, in sixteenths of a degree
   localparam logic [HUE_W-1:0]  HUE_MAX     = 13'd5759;
   localparam logic [FRAC_W-1:0] SECTOR_SPAN = 10'd960;
   localparam int unsigned       SPAN_SHIFT  = 6;   // 960 = 64 * 15
   localparam int unsigned       SPAN_ODD    = 15;

   // Pipeline depth and lane numbering of the two interpolated terms
   localparam int unsigned NSTAGE = 8;
   localparam int unsigned LANES  = 2;
   localparam int unsigned LANE_Q = 0;
   localparam int unsigned LANE_T = 1;

   // Source of one output channel
   typedef enum logic [1:0] {
      SRC_V = 2'd0,
      SRC_P = 2'd1,
      SRC_Q = 2'd2,
      SRC_T = 2'd3
   } src_type;

   typedef struct packed {
      src_type red;
      src_type green;
      src_type blue;
   } route_type;

   // Sector of a clamped hue
   function automatic logic [SECT_W-1:0] hue_sector(input logic [HUE_W-1:0] hue);
      logic [SECT_W-1:0] sect;
      if (hue >= 13'd4800) begin
         sect = 3'd5;
      end else if (hue >= 13'd3840) begin
         sect = 3'd4;
      end else if (hue >= 13'd2880) begin
         sect = 3'd3;
      end else if (hue >= 13'd1920) begin
         sect = 3'd2;
      end else if (hue >= 13'd960) begin
         sect = 3'd1;
      end else begin
         sect = 3'd0;
      end
      return sect;
   endfunction

   // First hue of a sector
   function automatic logic [HUE_W-1:0] sector_base(input logic [SECT_W-1:0] sect);
      logic [HUE_W-1:0] base;
      case (sect)
         3'd0:    base = 13'd0;
         3'd1:    base = 13'd960;
         3'd2:    base = 13'd1920;
         3'd3:    base = 13'd2880;
         3'd4:    base = 13'd3840;
         3'd5:    base = 13'd4800;
         default: base = 13'd4800;
      endcase
      return base;
   endfunction

   // Channel routing per sector
   function automatic route_type sector_route(input logic [SECT_W-1:0] sect);
      route_type rt;
      case (sect)
         3'd0:    rt = '{red: SRC_V, green: SRC_T, blue: SRC_P};
         3'd1:    rt = '{red: SRC_Q, green: SRC_V, blue: SRC_P};
         3'd2:    rt = '{red: SRC_P, green: SRC_V, blue: SRC_T};
         3'd3:    rt = '{red: SRC_P, green: SRC_Q, blue: SRC_V};
         3'd4:    rt = '{red: SRC_T, green: SRC_P, blue: SRC_V};
         3'd5:    rt = '{red: SRC_V, green: SRC_P, blue: SRC_Q};
         default: rt = '{red: SRC_V, green: SRC_P, blue: SRC_Q};
      endcase
      return rt;
   endfunction

endpackage

// ----- sv/hsv_to_rgb_convert.sv -----
// HSV to RGB pixel converter. Takes one pixel per clock while the output is
// not stalled and returns it as RGB: the first of eight register stages
// captures the item at the accepting edge and the last one drives the result.
// The whole pipeline holds only while a result waits on the output with
// rsp_tready low and moves whenever the output register is free or taken,
// so one pixel per cycle flows through when the sink keeps up. Hue is in
// sixteenths of a degree and clamps at 5759; saturation and
// brightness use full scale M = 2^CHANNEL_BITS - 1 as 1.0. Channels are v,
// p = v(M-s)/M, q = v(K-s*f)/K and t = v(K-s(960-f))/K with K = 960M, each
// truncated; division by M and by K is done with reciprocal products and a
// one-step correction spread over the stages.
`include "hsv_to_rgb_convert_defines.svh"

module hsv_to_rgb_convert #(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   // req_tdata, low bit up: hue[12:0], saturation, brightness, zero fill
   input  logic [((hsv2rgb_pkg::HUE_W + 2*CHANNEL_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // rsp_tdata, low bit up: red, green, blue, zero fill
   output logic [((3*CHANNEL_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready
);

   localparam int unsigned CB     = CHANNEL_BITS;
   localparam int unsigned HW     = hsv2rgb_pkg::HUE_W;
   localparam int unsigned FW     = hsv2rgb_pkg::FRAC_W;
   localparam int unsigned SW     = hsv2rgb_pkg::SECT_W;
   localparam int unsigned NL     = hsv2rgb_pkg::LANES;
   localparam int unsigned NS     = hsv2rgb_pkg::NSTAGE;
   localparam int unsigned RSP_W  = ((3*CB + 7) / 8) * 8;
   localparam int unsigned KW     = CB + FW;          // s * frac and K
   localparam int unsigned XPW    = 2*CB;             // v * (M - s)
   localparam int unsigned XW     = 2*CB + FW;        // v * (K - s * frac)
   localparam int unsigned X6W    = XW - hsv2rgb_pkg::SPAN_SHIFT;
   localparam int unsigned LW     = CB + 2;           // low split of x6
   localparam int unsigned HIW    = X6W - LW;
   localparam int unsigned RW     = CB + 1;           // reciprocal width
   localparam int unsigned PW     = LW + RW;
   localparam int unsigned SUMW   = X6W + RW;
   localparam int unsigned DW     = CB + 4;
   localparam int unsigned CHMAX_I = (1 << CB) - 1;
   localparam int unsigned DIV_I  = hsv2rgb_pkg::SPAN_ODD * CHMAX_I;

   localparam logic [CB-1:0]  CH_MAX  = CB'(CHMAX_I);
   localparam logic [KW-1:0]  K_SCALE = KW'(CHMAX_I * 960);
   localparam logic [DW-1:0]  DIV_D   = DW'(DIV_I);
   localparam logic [X6W-1:0] DIV_D2  = X6W'(2 * DIV_I);
   localparam logic [XPW-1:0] CH_MAX2 = XPW'(2 * CHMAX_I);
   localparam logic [63:0]    RECIP_FULL = (64'd1 << X6W) / 64'(DIV_I);
   localparam logic [RW-1:0]  RECIP   = RECIP_FULL[RW-1:0];

   // Unpack the request
   logic [HW-1:0] req_hue;
   logic [CB-1:0] req_sat;
   logic [CB-1:0] req_bri;
   assign req_hue = req_tdata[HW-1:0];
   assign req_sat = req_tdata[HW +: CB];
   assign req_bri = req_tdata[HW+CB +: CB];

   // Whole pipeline moves when the output register is free or taken
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   logic [NS-1:0] stage_valid_ff, stage_valid_in;
   assign stage_valid_in = {stage_valid_ff[NS-2:0], req_tvalid};

   // Stage 1: clamp hue, split into sector and fraction
   logic [HW-1:0] hue_clip;
   logic [SW-1:0] sector_s1_in, sector_s1_ff;
   logic [FW-1:0] frac_s1_in, frac_s1_ff;
   logic [CB-1:0] sat_s1_ff, bri_s1_ff;

   always_comb begin
      hue_clip     = (req_hue > hsv2rgb_pkg::HUE_MAX) ? hsv2rgb_pkg::HUE_MAX : req_hue;
      sector_s1_in = hsv2rgb_pkg::hue_sector(hue_clip);
      frac_s1_in   = FW'(hue_clip - hsv2rgb_pkg::sector_base(sector_s1_in));
   end

   // Stage 2: saturation products and complement
   logic [NL-1:0][KW-1:0] prod_s2_in, prod_s2_ff;
   logic [FW-1:0] span_rem;
   logic [CB-1:0] ms_s2_in, ms_s2_ff;
   logic [CB-1:0] bri_s2_ff;
   logic [SW-1:0] sector_s2_ff;

   always_comb begin
      span_rem   = hsv2rgb_pkg::SECTOR_SPAN - frac_s1_ff;
      prod_s2_in[hsv2rgb_pkg::LANE_Q] = KW'(sat_s1_ff) * KW'(frac_s1_ff);
      prod_s2_in[hsv2rgb_pkg::LANE_T] = KW'(sat_s1_ff) * KW'(span_rem);
      ms_s2_in   = CH_MAX - sat_s1_ff;
   end

   // Stage 3: scale by brightness
   logic [XPW-1:0] xp_s3_in, xp_s3_ff;
   logic [NL-1:0][XW-1:0] x_s3_in, x_s3_ff;
   logic [CB-1:0] bri_s3_ff;
   logic [SW-1:0] sector_s3_ff;

   always_comb begin
      xp_s3_in = XPW'(bri_s2_ff) * XPW'(ms_s2_ff);
      for (int i = 0; i < NL; i++) begin
         x_s3_in[i] = XW'(bri_s2_ff) * XW'(K_SCALE - prod_s2_ff[i]);
      end
   end

   // Stage 4: quotient estimates (p by series, q and t by split reciprocal)
   logic [XPW:0]   pe_sum;
   logic [CB-1:0]  pe_s4_in, pe_s4_ff;
   logic [XPW-1:0] xp_s4_ff;
   logic [NL-1:0][X6W-1:0] x6_s3;
   logic [NL-1:0][PW-1:0]  pl_s4_in, pl_s4_ff, ph_s4_in, ph_s4_ff;
   logic [NL-1:0][X6W-1:0] x6_s4_ff;
   logic [CB-1:0] bri_s4_ff;
   logic [SW-1:0] sector_s4_ff;

   always_comb begin
      pe_sum   = {1'b0, xp_s3_ff} + (XPW+1)'(xp_s3_ff >> CB);
      pe_s4_in = pe_sum[CB +: CB];
      for (int i = 0; i < NL; i++) begin
         x6_s3[i]    = x_s3_ff[i][XW-1:hsv2rgb_pkg::SPAN_SHIFT];
         pl_s4_in[i] = PW'(x6_s3[i][LW-1:0]) * PW'(RECIP);
         ph_s4_in[i] = PW'(x6_s3[i][LW +: HIW]) * PW'(RECIP);
      end
   end

   // Stage 5: correct p, combine partial products of q and t
   logic [XPW-1:0] pm_s4, rem_p;
   logic [CB-1:0]  p_s5_in, p_s5_ff;
   logic [NL-1:0][SUMW-1:0] rsum;
   logic [NL-1:0][CB-1:0]   q0_s5_in, q0_s5_ff;
   logic [NL-1:0][X6W-1:0]  x6_s5_ff;
   logic [CB-1:0] bri_s5_ff;
   logic [SW-1:0] sector_s5_ff;

   always_comb begin
      pm_s4   = (XPW'(pe_s4_ff) << CB) - XPW'(pe_s4_ff);
      rem_p   = xp_s4_ff - pm_s4;
      p_s5_in = (rem_p >= XPW'(CH_MAX)) ? pe_s4_ff + CB'(1) : pe_s4_ff;
      for (int i = 0; i < NL; i++) begin
         rsum[i]     = (SUMW'(ph_s4_ff[i]) << LW) + SUMW'(pl_s4_ff[i]);
         q0_s5_in[i] = rsum[i][X6W +: CB];
      end
   end

   // Stage 6: multiply estimates back by the divisor
   logic [NL-1:0][X6W-1:0] qd_s6_in, qd_s6_ff, x6_s6_ff;
   logic [NL-1:0][CB-1:0]  q0_s6_ff;
   logic [CB-1:0] p_s6_ff, bri_s6_ff;
   logic [SW-1:0] sector_s6_ff;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         qd_s6_in[i] = X6W'(q0_s5_ff[i]) * X6W'(DIV_D);
      end
   end

   // Stage 7: correct q and t by one step
   logic [NL-1:0][X6W-1:0] rem_qt;
   logic [NL-1:0][CB-1:0]  qt_s7_in, qt_s7_ff;
   logic [CB-1:0] p_s7_ff, bri_s7_ff;
   logic [SW-1:0] sector_s7_ff;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         rem_qt[i]   = x6_s6_ff[i] - qd_s6_ff[i];
         qt_s7_in[i] = (rem_qt[i] >= X6W'(DIV_D)) ? q0_s6_ff[i] + CB'(1) : q0_s6_ff[i];
      end
   end

   // Stage 8: route terms to channels
   function automatic logic [CB-1:0] pick(input hsv2rgb_pkg::src_type src,
                                          input logic [CB-1:0] v,
                                          input logic [CB-1:0] p,
                                          input logic [CB-1:0] q,
                                          input logic [CB-1:0] t);
      logic [CB-1:0] r;
      case (src)
         hsv2rgb_pkg::SRC_V: r = v;
         hsv2rgb_pkg::SRC_P: r = p;
         hsv2rgb_pkg::SRC_Q: r = q;
         hsv2rgb_pkg::SRC_T: r = t;
         default:            r = v;
      endcase
      return r;
   endfunction

   hsv2rgb_pkg::route_type route_s7;
   logic [CB-1:0] red_in, green_in, blue_in;
   logic [CB-1:0] red_ff, green_ff, blue_ff;

   always_comb begin
      route_s7 = hsv2rgb_pkg::sector_route(sector_s7_ff);
      red_in   = pick(route_s7.red, bri_s7_ff, p_s7_ff,
                      qt_s7_ff[hsv2rgb_pkg::LANE_Q], qt_s7_ff[hsv2rgb_pkg::LANE_T]);
      green_in = pick(route_s7.green, bri_s7_ff, p_s7_ff,
                      qt_s7_ff[hsv2rgb_pkg::LANE_Q], qt_s7_ff[hsv2rgb_pkg::LANE_T]);
      blue_in  = pick(route_s7.blue, bri_s7_ff, p_s7_ff,
                      qt_s7_ff[hsv2rgb_pkg::LANE_Q], qt_s7_ff[hsv2rgb_pkg::LANE_T]);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else if (advance) begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Payload registers: advance together, hold on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         sector_s1_ff <= sector_s1_in;
         frac_s1_ff   <= frac_s1_in;
         sat_s1_ff    <= req_sat;
         bri_s1_ff    <= req_bri;

         prod_s2_ff   <= prod_s2_in;
         ms_s2_ff     <= ms_s2_in;
         bri_s2_ff    <= bri_s1_ff;
         sector_s2_ff <= sector_s1_ff;

         xp_s3_ff     <= xp_s3_in;
         x_s3_ff      <= x_s3_in;
         bri_s3_ff    <= bri_s2_ff;
         sector_s3_ff <= sector_s2_ff;

         pe_s4_ff     <= pe_s4_in;
         xp_s4_ff     <= xp_s3_ff;
         pl_s4_ff     <= pl_s4_in;
         ph_s4_ff     <= ph_s4_in;
         x6_s4_ff     <= x6_s3;
         bri_s4_ff    <= bri_s3_ff;
         sector_s4_ff <= sector_s3_ff;

         p_s5_ff      <= p_s5_in;
         q0_s5_ff     <= q0_s5_in;
         x6_s5_ff     <= x6_s4_ff;
         bri_s5_ff    <= bri_s4_ff;
         sector_s5_ff <= sector_s4_ff;

         qd_s6_ff     <= qd_s6_in;
         x6_s6_ff     <= x6_s5_ff;
         q0_s6_ff     <= q0_s5_ff;
         p_s6_ff      <= p_s5_ff;
         bri_s6_ff    <= bri_s5_ff;
         sector_s6_ff <= sector_s5_ff;

         qt_s7_ff     <= qt_s7_in;
         p_s7_ff      <= p_s6_ff;
         bri_s7_ff    <= bri_s6_ff;
         sector_s7_ff <= sector_s6_ff;

         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
      end
   end

   // Drive the result channel
   assign rsp_tvalid = stage_valid_ff[NS-1];
   assign rsp_tdata  = RSP_W'({blue_ff, green_ff, red_ff});

   // Checks
   `HSV_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (stage_valid_ff == '0), "valid bits survive reset")
   `HSV_ASSERT(a_accept_enters, clock, reset, (req_tvalid && req_tready) |=> stage_valid_ff[0], "accepted item missing from first stage")
   `HSV_ASSERT(a_sector_range, clock, reset, stage_valid_ff[0] |-> (sector_s1_ff <= 3'd5), "sector beyond five")
   `HSV_ASSERT(a_p_residual, clock, reset, stage_valid_ff[3] |-> (rem_p < CH_MAX2), "p estimate off by more than one")
   `HSV_ASSERT(a_q_residual, clock, reset, stage_valid_ff[5] |-> (rem_qt[hsv2rgb_pkg::LANE_Q] < DIV_D2), "q estimate off by more than one")
   `HSV_ASSERT(a_t_residual, clock, reset, stage_valid_ff[5] |-> (rem_qt[hsv2rgb_pkg::LANE_T] < DIV_D2), "t estimate off by more than one")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CH_BITS    = 8;
   localparam int unsigned REQ_W      = ((hsv2rgb_pkg::HUE_W + 2*CH_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_W      = ((3*CH_BITS + 7) / 8) * 8;
   localparam int unsigned HUE_LIMIT  = 5759;
   localparam int unsigned HUE_TOP    = 8191;
   localparam int unsigned SPAN       = 960;
   localparam longint unsigned FULL   = 255;
   localparam longint unsigned K_FULL = 255 * 960;
   localparam int unsigned PIPE_DEPTH = 8;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   // Expected pixel store: predicts each accepted HSV item, checks each RGB result
   class pixel_checker;
      rgb_type     expected_rgb[$];
      int unsigned failures = 0;

      function rgb_type predict_rgb(logic [12:0] hue_in, logic [7:0] sat, logic [7:0] bright);
         int unsigned     hue;
         int unsigned     sector;
         int unsigned     frac;
         longint unsigned v;
         longint unsigned s;
         logic [7:0]      p8;
         logic [7:0]      q8;
         logic [7:0]      t8;
         rgb_type         px;
         hue = 32'(hue_in);
         if (hue > HUE_LIMIT) begin
            hue = HUE_LIMIT;
         end
         sector = hue / SPAN;
         frac   = hue % SPAN;
         v      = 64'(bright);
         s      = 64'(sat);
         p8 = 8'((v * (FULL - s)) / FULL);
         q8 = 8'((v * (K_FULL - s * frac)) / K_FULL);
         t8 = 8'((v * (K_FULL - s * (SPAN - frac))) / K_FULL);
         // route v, p, q, t to the channels by sector; no saturation means grey
         if (sat == 8'd0) begin
            px.red = bright; px.green = bright; px.blue = bright;
         end else begin
            case (sector)
               0:       begin px.red = bright; px.green = t8;     px.blue = p8;     end
               1:       begin px.red = q8;     px.green = bright; px.blue = p8;     end
               2:       begin px.red = p8;     px.green = bright; px.blue = t8;     end
               3:       begin px.red = p8;     px.green = q8;     px.blue = bright; end
               4:       begin px.red = t8;     px.green = p8;     px.blue = bright; end
               default: begin px.red = bright; px.green = p8;     px.blue = q8;     end
            endcase
         end
         return px;
      endfunction

      function void note_pixel(logic [12:0] hue, logic [7:0] sat, logic [7:0] bright);
         expected_rgb.push_back(predict_rgb(hue, sat, bright));
      endfunction

      function void check_pixel(rgb_type got);
         rgb_type want;
         if (expected_rgb.size() == 0) begin
            failures++;
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time,
                     got.red, got.green, got.blue);
         end else begin
            want = expected_rgb.pop_front();
            if (want.red !== got.red || want.green !== got.green || want.blue !== got.blue) begin
               failures++;
               $display("%0t: pixel mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        $time, want.red, want.green, want.blue,
                        got.red, got.green, got.blue);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_rgb.size();
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;

   pixel_checker board = new;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  hold_len = 0;

   hsv_to_rgb_convert #(.CHANNEL_BITS(CH_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #4 clock = ~clock;

   // Watch both channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_pixel(req_tdata[12:0], req_tdata[20:13], req_tdata[28:21]);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_pixel(rsp_tdata[23:0]);
         end
      end
   end

   // Drive the sink: random stalls, or a long hold-off when requested
   initial begin : sink
      while (reset) @(posedge clock);
      forever begin
         if (hold_len != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clock);
         end
      end
   end

   // Offer one item and hold it until accepted
   task automatic send_pixel(input logic [12:0] hue, input logic [7:0] sat,
                             input logic [7:0] bright);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, bright, sat, hue};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [7:0] pick_channel();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return 8'd0;
      if (r < 20) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_random_pixel();
      int unsigned r;
      logic [12:0] hue;
      r = $urandom_range(99);
      if (r < 8) begin
         hue = 13'($urandom_range(HUE_TOP, HUE_LIMIT + 1));
      end else if (r < 16) begin
         // land on a sector edge
         hue = 13'($urandom_range(5) * SPAN + $urandom_range(1) * (SPAN - 1));
      end else begin
         hue = 13'($urandom_range(HUE_LIMIT));
      end
      send_pixel(hue, pick_channel(), pick_channel());
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned count);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_random_pixel();
   endtask

   initial begin : stimulus
      int unsigned n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: sector edges, hue above range, grey, field extremes
      send_pixel(13'd0, 8'd255, 8'd255);
      send_pixel(13'd959, 8'd255, 8'd255);
      send_pixel(13'd960, 8'd255, 8'd255);
      send_pixel(13'd1919, 8'd200, 8'd255);
      send_pixel(13'd1920, 8'd255, 8'd128);
      send_pixel(13'd2879, 8'd1, 8'd255);
      send_pixel(13'd2880, 8'd255, 8'd255);
      send_pixel(13'd3839, 8'd128, 8'd77);
      send_pixel(13'd3840, 8'd255, 8'd255);
      send_pixel(13'd4799, 8'd254, 8'd1);
      send_pixel(13'd4800, 8'd255, 8'd255);
      send_pixel(13'd5759, 8'd255, 8'd255);
      send_pixel(13'd5760, 8'd255, 8'd255);
      send_pixel(13'd8191, 8'd170, 8'd200);
      send_pixel(13'd4096, 8'd85, 8'd170);
      send_pixel(13'd480, 8'd0, 8'd255);
      send_pixel(13'd3000, 8'd0, 8'd99);
      send_pixel(13'd5000, 8'd0, 8'd0);
      send_pixel(13'd2000, 8'd255, 8'd0);
      send_pixel(13'd1440, 8'd127, 8'd255);
      send_pixel(13'd5000, 8'd255, 8'd254);

      // No idling, with a long sink hold-off that backs up the pipeline
      run_phase(0, 0, 150);
      hold_len = 60;
      run_phase(0, 0, 60);
      // Pause the source until every pixel is out
      req_tvalid <= 1'b0;
      wait_drained();
      run_phase(0, 0, 150);

      run_phase(69, 0, 380);
      run_phase(0, 69, 380);
      run_phase(8, 8, 380);

      // Drain and let the pipeline settle
      req_tvalid     <= 1'b0;
      recv_stall_pct = 0;
      n = 0;
      while (board.pending() != 0 && n < 20000) begin
         @(posedge clock);
         n++;
      end
      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (board.pending() != 0) begin
         board.failures++;
         $display("%0t: %0d expected pixels never arrived", $time, board.pending());
      end
      if (board.failures == 0) begin
         $display("hsv_to_rgb_convert verification clean");
      end else begin
         $display("hsv_to_rgb_convert verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2ms;
      $display("hsv_to_rgb_convert verification failed");
      $finish;
   end

endmodule
